// ----- src/vdcd_pkg.sv -----
// Package: shared types and constants for the varint delta column decoder.
`default_nettype none
package vdcd_pkg;

  // LEB128 group geometry
  localparam int unsigned GROUP_BITS      = 7;
  localparam int unsigned VALUE_BITS      = 64;
  localparam int unsigned CONT_BIT        = 7;
  localparam logic [6:0]  DATA_MASK       = 7'h7F;
  localparam logic [3:0]  LAST_FULL_GROUP = 4'd8;
  localparam logic [3:0]  TOP_GROUP       = 4'd9;
  localparam logic [3:0]  MAX_GROUP       = 4'd15;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] code_byte;
    logic       column_start;
    logic       column_end;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic [VALUE_BITS-1:0] decoded_value;
    logic                  first_of_column;
    logic                  overflow_seen;
    logic                  truncated;
    logic                  end_of_column;
  } out_item_t;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [VALUE_BITS-1:0] partial_value;
    logic [3:0]            group_count;
    logic                  awaiting_first;
    logic                  lost_bits;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    partial_value:  '0,
    group_count:    '0,
    awaiting_first: 1'b1,
    lost_bits:      1'b0
  };

endpackage
`default_nettype wire

// ----- src/vdcd_gather.sv -----
// Combinational byte step: gather one LEB128 group, apply base, form result.
`default_nettype none
module vdcd_gather (
  input  wire vdcd_pkg::dec_state_t        state,
  input  wire vdcd_pkg::in_item_t          item,
  input  wire logic [63:0]                 base_value,
  output vdcd_pkg::dec_state_t             state_next,
  output vdcd_pkg::out_item_t              result,
  output logic                             result_valid
);
  import vdcd_pkg::*;

  dec_state_t      cur;
  dec_state_t      upd;
  logic [6:0]      data;
  logic [5:0]      shamt;
  logic [63:0]     shifted;
  logic            more;

  always_comb begin
    // Column start clears any unfinished value before the byte is used
    cur = item.column_start ? STATE_RESET : state;
    data = item.code_byte[6:0] & DATA_MASK;
    more = item.code_byte[CONT_BIT];
    shamt = 6'(cur.group_count) * 6'(GROUP_BITS);
    shifted = 64'(data) << shamt;

    // Gather the group; drop bits beyond the top of the value
    upd = cur;
    if (cur.group_count <= LAST_FULL_GROUP) begin
      upd.partial_value = cur.partial_value | shifted;
    end else if (cur.group_count == TOP_GROUP) begin
      upd.partial_value[VALUE_BITS-1] = cur.partial_value[VALUE_BITS-1] | data[0];
      if (data[6:1] != '0) upd.lost_bits = 1'b1;
    end else if (data != '0) begin
      upd.lost_bits = 1'b1;
    end

    // Emit on a final byte, or on a column end that cuts a value short
    result_valid = !more || item.column_end;
    result.decoded_value   = upd.awaiting_first ? upd.partial_value
                                                : upd.partial_value + base_value;
    result.first_of_column = upd.awaiting_first;
    result.overflow_seen   = upd.lost_bits;
    result.truncated       = more;
    result.end_of_column   = item.column_end;

    // Advance state
    state_next = upd;
    if (!more) begin
      state_next = STATE_RESET;
      state_next.awaiting_first = 1'b0;
    end else if (upd.group_count < MAX_GROUP) begin
      state_next.group_count = upd.group_count + 4'd1;
    end
    if (item.column_end) state_next = STATE_RESET;
  end

endmodule
`default_nettype wire

// ----- src/varint_delta_column_decoder_top.sv -----
// Top level: varint delta column decoder with state and result registers.
// A result appears on out_valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; in_ready holds only while a result waits unaccepted.
// Timing is set by the 64-bit base adder between the byte input and the result register.
// Reset (rst, synchronous, active high) clears the base register, the decoder state and
// out_valid; in_ready stays low during reset.
`default_nettype none
module varint_delta_column_decoder_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire vdcd_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output vdcd_pkg::out_item_t       out_data,
  input  wire logic                 cfg_wen,
  input  wire logic [63:0]          cfg_wdata
);
  import vdcd_pkg::*;

  logic [63:0] base_reg;
  dec_state_t  state;
  dec_state_t  state_next;
  out_item_t   result;
  logic        result_valid;
  logic        in_fire;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  vdcd_gather u_gather (
    .state        (state),
    .item         (in_data),
    .base_value   (base_reg),
    .state_next   (state_next),
    .result       (result),
    .result_valid (result_valid)
  );

  // Hold the base register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg <= '0;
    end else if (cfg_wen) begin
      base_reg <= cfg_wdata;
    end
  end

  // Advance decoder state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Result register: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= result_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && result_valid) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

// ----- src/vdcd_checker.sv -----
// Checker: port-level properties of the decoder, bound to the top level.
`default_nettype none
module vdcd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire vdcd_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire vdcd_pkg::out_item_t out_data
);
  import vdcd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input side stalls only behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the result register");

  // A final byte yields a result next cycle
  a_emit: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.code_byte[CONT_BIT] |=> out_valid)
    else $error("final byte produced no result");

  // A mid-column continuation byte yields nothing
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.code_byte[CONT_BIT] && !in_data.column_end
    |=> !out_valid)
    else $error("continuation byte produced a result");

  // Truncation only at a column end
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.truncated |-> out_data.end_of_column)
    else $error("truncated result without end of column");

endmodule

bind varint_delta_column_decoder_top vdcd_checker u_vdcd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
